/* src/potential_field_accumulator_macros.svh */
// Assertion macros for the potential field accumulator controller.
`ifndef POTENTIAL_FIELD_ACCUMULATOR_MACROS_SVH
`define POTENTIAL_FIELD_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pfa_pkg.sv */
// Package: widths, register indexes, controller states and command/status types.
package pfa_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;      // dx, dy
    localparam int SQ_W      = 2 * COORD_W;      // dx*dx fits below 2^32
    localparam int RAD_W     = SQ_W + 2;         // dx*dx + dy*dy, even width
    localparam int ROOT_W    = RAD_W / 2;        // floor sqrt
    localparam int SQREM_W   = ROOT_W + 1;       // sqrt partial remainder
    localparam int CUTOFF_W  = 15;
    localparam int GAIN_W    = 16;
    localparam int MASS_W    = 16;
    localparam int NUM_SHIFT = 7;
    localparam int NUM_W     = GAIN_W + MASS_W + NUM_SHIFT;
    localparam int SUM_W     = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam int ROOT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = NUM_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [SUM_W-1:0] MAG_LIMIT = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = CUTOFF_W'(410);
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(1311);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SQUARE = 8'b0000_0010,
        S_SUM    = 8'b0000_0100,
        S_ROOT   = 8'b0000_1000,
        S_CHECK  = 8'b0001_0000,
        S_DIVIDE = 8'b0010_0000,
        S_ACCUM  = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load;       // capture transaction fields
        logic square;     // form squares and gain*mass
        logic sum;        // form dx^2+dy^2, clear sqrt state
        logic root_step;  // one sqrt digit
        logic check;      // compare root with cutoff, clear divider
        logic div_step;   // one quotient bit
        logic accum;      // add term into magnitude
        logic emit;       // move sum to output, clear magnitude
    } cmd_t;

    typedef struct packed {
        logic above;      // root > cutoff
        logic last;       // captured last_body flag
    } status_t;

endpackage

/* src/pfa_datapath.sv */
// Datapath: config registers, squares, digit-serial sqrt, restoring divider, accumulator.
module pfa_datapath
    import pfa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic signed [COORD_W-1:0]   point_x,
    input  logic signed [COORD_W-1:0]   point_y,
    input  logic signed [COORD_W-1:0]   body_x,
    input  logic signed [COORD_W-1:0]   body_y,
    input  logic [MASS_W-1:0]           body_mass,
    input  logic                        last_body,
    input  cmd_t                        cmd,
    output status_t                     status,
    output logic signed [SUM_W-1:0]     warp_value
);

    logic [CUTOFF_W-1:0]       cutoff_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic [SUM_W-1:0]          mag_reg, mag_next;

    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [MASS_W-1:0]         mass_reg;
    logic                      last_reg;
    logic [SQ_W-1:0]           dx2_reg, dy2_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [SQREM_W-1:0]        sqrem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic                      above_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [ROOT_W-1:0]         drem_reg;
    logic signed [SUM_W-1:0]   out_reg;

    logic signed [2*DIFF_W-1:0] dx_sq, dy_sq;
    logic [GAIN_W+MASS_W-1:0]   gm_prod;
    logic [SQREM_W+1:0]         sq_acc, sq_trial, sq_diff;
    logic                       sq_take;
    logic [ROOT_W:0]            dv_acc, dv_diff;
    logic                       dv_take;
    logic                       above;
    logic                       term_sat;
    logic [SUM_W:0]             mag_sum;

    // Multipliers, each feeding its own register
    assign dx_sq   = dx_reg * dx_reg;
    assign dy_sq   = dy_reg * dy_reg;
    assign gm_prod = gain_reg * mass_reg;

    // One sqrt digit: bring down two bits, try (root*4 + 1)
    assign sq_acc   = {sqrem_reg, rad_reg[RAD_W-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_take  = (sq_acc >= sq_trial);
    assign sq_diff  = sq_acc - sq_trial;

    // One quotient bit: bring down the top numerator bit
    assign dv_acc  = {drem_reg, num_reg[NUM_W-1]};
    assign dv_take = (dv_acc >= {1'b0, root_reg});
    assign dv_diff = dv_acc - {1'b0, root_reg};

    assign above = (root_reg > {{(ROOT_W-CUTOFF_W){1'b0}}, cutoff_reg});

    // Saturating magnitude update
    assign term_sat = |num_reg[NUM_W-1:SUM_W-1];
    assign mag_sum  = {1'b0, mag_reg} + {2'b00, num_reg[SUM_W-2:0]};

    always_comb
    begin
        mag_next = mag_reg;
        if (cmd.accum && above_reg)
        begin
            if (term_sat || (mag_sum > {1'b0, MAG_LIMIT}))
                mag_next = MAG_LIMIT;
            else
                mag_next = mag_sum[SUM_W-1:0];
        end
        if (cmd.emit)
            mag_next = '0;
    end

    // Config and running magnitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUTOFF_RESET;
            gain_reg   <= GAIN_RESET;
            mag_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CUTOFF: cutoff_reg <= cfg_data[CUTOFF_W-1:0];
                    CFG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                    default:    ;
                endcase
            end
            mag_reg <= mag_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg   <= DIFF_W'(point_x) - DIFF_W'(body_x);
            dy_reg   <= DIFF_W'(point_y) - DIFF_W'(body_y);
            mass_reg <= body_mass;
            last_reg <= last_body;
        end
        if (cmd.square)
        begin
            dx2_reg <= dx_sq[SQ_W-1:0];
            dy2_reg <= dy_sq[SQ_W-1:0];
            num_reg <= {gm_prod, {NUM_SHIFT{1'b0}}};
        end
        if (cmd.sum)
        begin
            rad_reg   <= {2'b00, dx2_reg} + {2'b00, dy2_reg};
            sqrem_reg <= '0;
            root_reg  <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (sq_take)
            begin
                sqrem_reg <= sq_diff[SQREM_W-1:0];
                root_reg  <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sqrem_reg <= sq_acc[SQREM_W-1:0];
                root_reg  <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.check)
        begin
            above_reg <= above;
            drem_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            drem_reg <= dv_take ? dv_diff[ROOT_W-1:0] : dv_acc[ROOT_W-1:0];
            num_reg  <= {num_reg[NUM_W-2:0], dv_take};
        end
        if (cmd.emit)
            out_reg <= ~mag_reg + SUM_W'(1);
    end

    assign status.above = above;
    assign status.last  = last_reg;
    assign warp_value   = out_reg;

endmodule

/* src/pfa_controller.sv */
// Controller: sequences capture, sqrt, divide, accumulate and output handoff.
module pfa_controller
    import pfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

`include "potential_field_accumulator_macros.svh"

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic               slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                count_next = '0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (count_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    count_next = '0;
                    state_next = S_CHECK;
                end
                else
                    count_next = count_reg + CNT_W'(1);
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.above ? S_DIVIDE : S_ACCUM;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (count_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    count_next = '0;
                    state_next = S_ACCUM;
                end
                else
                    count_next = count_reg + CNT_W'(1);
            end
            S_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = status.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                // wait until the output register is free
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (cmd.emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Checks
    `PFA_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == S_SQUARE, "accepted transaction did not start work")
    `PFA_ASSERT_NOW(a_result_from_emit, $rose(out_valid_reg), $past(state_reg) == S_EMIT, "result appeared without emit")
    `PFA_ASSERT_NOW(a_root_count, state_reg == S_ROOT, count_reg < CNT_W'(ROOT_STEPS), "sqrt step count overran")
    `PFA_ASSERT_NOW(a_emit_no_overwrite, cmd.emit, !out_valid_reg || out_ready, "pending result overwritten")

endmodule

/* src/potential_field_accumulator.sv */
// Top level: softened potential sum over a list of bodies for one query point.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------------
//  input    | in_valid / in_ready     | point_x, point_y, body_x, body_y, body_mass,
//           |                         | last_body
//  output   | out_valid / out_ready   | warp_value
//  config   | cfg_we                  | cfg_index, cfg_data
//
//  One transaction at a time. A body at or inside the cutoff holds the input through the
//  square, sum, digit-serial square root, check and accumulate states; one outside it
//  also through the restoring divider. Square root and divider each take one bit per
//  cycle. A last body adds the emit state to hand its sum to the output register, held
//  there while a previous result is still waiting; in_ready stays low meanwhile.
//  Reset clears the running sum and restores both config registers; no sweep.
module potential_field_accumulator
    import pfa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COORD_W-1:0]   point_x,
    input  logic signed [COORD_W-1:0]   point_y,
    input  logic signed [COORD_W-1:0]   body_x,
    input  logic signed [COORD_W-1:0]   body_y,
    input  logic [MASS_W-1:0]           body_mass,
    input  logic                        last_body,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SUM_W-1:0]     warp_value
);

    cmd_t    cmd;
    status_t status;

    // Sequencer
    pfa_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic
    pfa_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .point_x    (point_x),
        .point_y    (point_y),
        .body_x     (body_x),
        .body_y     (body_y),
        .body_mass  (body_mass),
        .last_body  (last_body),
        .cmd        (cmd),
        .status     (status),
        .warp_value (warp_value)
    );

endmodule

/* tb/potential_field_accumulator_tb.sv */
// Self-checking testbench for the potential field accumulator: random lists and stalls.
`timescale 1ns / 100ps

module potential_field_accumulator_tb
    import pfa_pkg::*;
();

    localparam int HOLD_CYCLES   = 800;   // long output back-pressure stretch
    localparam int SETTLE_CYCLES = 80;    // covers the slowest body plus the emit state
    localparam int MAX_BURST     = 17;

    typedef struct {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic [MASS_W-1:0]         mass;
        logic                      last;
    } body_t;

    // DUT ports
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = CFG_CUTOFF;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] point_x = '0;
    logic signed [COORD_W-1:0] point_y = '0;
    logic signed [COORD_W-1:0] body_x = '0;
    logic signed [COORD_W-1:0] body_y = '0;
    logic [MASS_W-1:0]         body_mass = '0;
    logic                      last_body = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [SUM_W-1:0]   warp_value;

    // Stimulus and scoreboard state
    body_t                     pending_bodies[$];
    body_t                     next_body;
    logic signed [SUM_W-1:0]   warp_expected[$];
    logic signed [SUM_W-1:0]   warp_model = '0;
    logic [CUTOFF_W-1:0]       cutoff_setting = CUTOFF_RESET;
    logic [GAIN_W-1:0]         gain_setting = GAIN_RESET;
    logic                      in_took = 1'b0;
    int                        bodies_queued = 0;
    int                        bodies_taken = 0;
    int                        fail_count = 0;
    int                        idle_percent = 0;
    int                        send_gap = 0;
    int                        recv_gap = 0;
    int                        holds_asked = 0;
    int                        holds_served = 0;
    int                        hold_left = 0;

    potential_field_accumulator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .body_x     (body_x),
        .body_y     (body_y),
        .body_mass  (body_mass),
        .last_body  (last_body),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .warp_value (warp_value)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Floor square root, two radicand bits per digit
    function automatic logic [ROOT_W-1:0] floor_root(input logic [RAD_W-1:0] radicand);
        logic [RAD_W-1:0] rest;
        logic [RAD_W-1:0] root;
        logic [RAD_W-1:0] probe;
        rest  = radicand;
        root  = '0;
        probe = RAD_W'(1) << (RAD_W - 2);
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[ROOT_W-1:0];
    endfunction

    // Fold one body into the running sum; a last body yields the expected warp value
    function automatic void accumulate_warp(
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py,
        input logic signed [COORD_W-1:0] bx,
        input logic signed [COORD_W-1:0] by,
        input logic [MASS_W-1:0]         mass,
        input logic                      last
    );
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [RAD_W:0]    sq_x;
        logic signed [RAD_W:0]    sq_y;
        logic [RAD_W-1:0]         radicand;
        logic [ROOT_W-1:0]        radius;
        logic [NUM_W-1:0]         numer;
        logic [NUM_W-1:0]         term;
        logic [SUM_W-1:0]         neg_sum;
        logic [SUM_W:0]           mag;
        dx       = px - bx;
        dy       = py - by;
        sq_x     = dx * dx;
        sq_y     = dy * dy;
        radicand = sq_x[RAD_W-1:0] + sq_y[RAD_W-1:0];
        radius   = floor_root(radicand);
        // At or inside the cutoff (zero distance included) nothing is added
        if (radius > cutoff_setting)
        begin
            numer   = (NUM_W'(gain_setting) * NUM_W'(mass)) << NUM_SHIFT;
            term    = numer / NUM_W'(radius);
            neg_sum = -warp_model;
            mag     = {1'b0, neg_sum};
            if (term >= NUM_W'(MAG_LIMIT))
            begin
                mag = MAG_LIMIT;
            end
            else
            begin
                mag = mag + term[SUM_W:0];
            end
            if (mag > MAG_LIMIT)
            begin
                mag = MAG_LIMIT;
            end
            warp_model = -mag[SUM_W-1:0];
        end
        if (last)
        begin
            warp_expected = {warp_expected, warp_model};
            warp_model = '0;
        end
    endfunction

    task automatic push_body(
        input int px,
        input int py,
        input int bx,
        input int by,
        input int mass,
        input logic last
    );
        body_t b;
        b.px   = COORD_W'(px);
        b.py   = COORD_W'(py);
        b.bx   = COORD_W'(bx);
        b.by   = COORD_W'(by);
        b.mass = MASS_W'(mass);
        b.last = last;
        pending_bodies = {pending_bodies, b};
        bodies_queued++;
    endtask

    // Block is idle once every body is taken, every result is back and the pipe has settled
    task automatic wait_drained();
        while (bodies_taken != bodies_queued || warp_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic retune(input logic [CUTOFF_W-1:0] cutoff, input logic [GAIN_W-1:0] gain);
        wait_drained();
        @(negedge clk);
        cfg_we         <= 1'b1;
        cfg_index      <= CFG_CUTOFF;
        cfg_data       <= CFG_W'(cutoff);
        cutoff_setting  = cutoff;
        @(negedge clk);
        cfg_index      <= CFG_GAIN;
        cfg_data       <= CFG_W'(gain);
        gain_setting    = gain;
        @(negedge clk);
        cfg_we         <= 1'b0;
    endtask

    // Random body lists sharing one query point each
    task automatic run_phase(input int n_items, input int idle_pct, input bit single_only);
        int count;
        int len;
        int px;
        int py;
        int bx;
        int by;
        int span;
        int mass;
        int pick;
        @(posedge clk);
        idle_percent = idle_pct;
        count = 0;
        while (count < n_items)
        begin
            if (single_only || $urandom_range(3) == 0)
            begin
                len = 1;
            end
            else
            begin
                len = $urandom_range(1, 12);
            end
            if ($urandom_range(1) == 0)
            begin
                px = $urandom_range(16'hFFFF);
                py = $urandom_range(16'hFFFF);
            end
            else
            begin
                px = $urandom_range(8191) - 4096;
                py = $urandom_range(8191) - 4096;
            end
            for (int k = 0; k < len; k++)
            begin
                pick = $urandom_range(7);
                span = int'(cutoff_setting) + 64;
                if (pick < 4)
                begin
                    bx = $urandom_range(16'hFFFF);
                    by = $urandom_range(16'hFFFF);
                end
                else if (pick < 7)
                begin
                    // near the cutoff circle
                    bx = px + $urandom_range(2 * span) - span;
                    by = py + $urandom_range(2 * span) - span;
                end
                else
                begin
                    bx = px;
                    by = py;
                end
                pick = $urandom_range(9);
                if (pick == 0)
                begin
                    mass = 0;
                end
                else if (pick == 1)
                begin
                    mass = 16'hFFFF;
                end
                else
                begin
                    mass = $urandom_range(16'hFFFF);
                end
                push_body(px, py, bx, by, mass, k == len - 1);
            end
            count += len;
        end
    endtask

    // Sender: loads the next body once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (send_gap > 0)
            begin
                send_gap  = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_bodies.size() != 0)
            begin
                next_body  = pending_bodies.pop_front();
                point_x   <= next_body.px;
                point_y   <= next_body.py;
                body_x    <= next_body.bx;
                body_y    <= next_body.by;
                body_mass <= next_body.mass;
                last_body <= next_body.last;
                in_valid  <= 1'b1;
                if (idle_percent != 0 && $urandom_range(99) < idle_percent)
                begin
                    send_gap = $urandom_range(1, MAX_BURST);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts plus the requested long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left  = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (holds_asked != holds_served)
        begin
            holds_served++;
            hold_left  = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap   = recv_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idle_percent != 0 && $urandom_range(99) < idle_percent)
            begin
                recv_gap = $urandom_range(1, MAX_BURST);
            end
        end
    end

    // Monitor: check results first, then predict from the accepted body
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_took <= 1'b0;
        end
        else
        begin
            in_took <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (warp_expected.size() == 0)
                begin
                    $error("warp_value %0d arrived with no result pending", warp_value);
                    fail_count++;
                end
                else if (warp_value !== warp_expected[0])
                begin
                    $error("warp_value mismatch: expected %0d, actual %0d",
                           warp_expected[0], warp_value);
                    fail_count++;
                    void'(warp_expected.pop_front());
                end
                else
                begin
                    void'(warp_expected.pop_front());
                end
            end
            if (in_valid && in_ready)
            begin
                bodies_taken++;
                accumulate_warp(point_x, point_y, body_x, body_y, body_mass, last_body);
            end
        end
    end

    // Main sequence
    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_percent = 25;

        // Reset settings: zero distance, distance equal to and just past the cutoff,
        // extreme coordinates, zero mass, back-to-back one-body lists
        push_body(0, 0, 0, 0, 16'hFFFF, 1'b1);
        push_body(410, 0, 0, 0, 1000, 1'b0);
        push_body(0, 411, 0, 0, 1000, 1'b1);
        push_body(-32768, -32768, 32767, 32767, 16'hFFFF, 1'b0);
        push_body(32767, 32767, -32768, -32768, 16'hFFFF, 1'b0);
        push_body(32767, -32768, -32768, 32767, 0, 1'b1);
        push_body(1000, -1000, 1500, -1000, 16'hFFFF, 1'b1);
        push_body(-4096, 4096, 4096, -4096, 12345, 1'b1);
        push_body(100, 100, -900, 100, 16'hFFFF, 1'b1);

        // Full gain, no cutoff: saturation in one term, by accumulation, and held there
        retune('0, '1);
        @(posedge clk);
        push_body(1, 0, 0, 0, 16'hFFFF, 1'b1);
        push_body(300, 0, 0, 0, 16'hFFFF, 1'b0);
        push_body(0, 300, 0, 0, 16'hFFFF, 1'b0);
        push_body(-300, 0, 0, 0, 16'hFFFF, 1'b1);
        push_body(5, 5, 5, 5, 16'hFFFF, 1'b1);
        push_body(-32768, 0, 32767, 0, 1, 1'b1);

        // Zero gain, widest cutoff
        retune('1, '0);
        @(posedge clk);
        push_body(-32768, 0, 32767, 0, 16'hFFFF, 1'b1);
        push_body(0, -32768, 0, 32767, 16'hFFFF, 1'b1);

        // Random phases over a range of settings
        retune(CUTOFF_RESET, GAIN_RESET);
        run_phase(140, 25, 1'b0);
        retune('0, '1);
        run_phase(140, 40, 1'b0);
        retune('1, '0);
        run_phase(100, 25, 1'b0);
        retune('1, '1);
        run_phase(140, 0, 1'b0);
        retune('0, GAIN_W'(1));
        run_phase(100, 25, 1'b0);
        repeat (2)
        begin
            retune(CUTOFF_W'($urandom_range(16'h7FFF)), GAIN_W'($urandom_range(16'hFFFF)));
            run_phase(140, 30, 1'b0);
        end

        // Long output hold while one-body lists keep coming, so the input backs up
        retune(CUTOFF_W'($urandom_range(2000)), GAIN_W'($urandom_range(16'hFFFF)));
        @(posedge clk);
        holds_asked++;
        run_phase(60, 0, 1'b1);

        // Closing stretch without idling
        retune(CUTOFF_RESET, GAIN_RESET);
        run_phase(200, 0, 1'b0);

        wait_drained();
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #6000000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/pfa_pkg.sv
src/pfa_datapath.sv
src/pfa_controller.sv
src/potential_field_accumulator.sv
tb/potential_field_accumulator_tb.sv
